// ----- rtl/core/clc_pkg.sv -----
// Shared constants, result codes and interface types for the code lock controller.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package clc_pkg;

	localparam int CodeLenDef = 3;
	localparam int MaxCodeLen = 16;

	localparam logic [7:0] STAR_KEY       = 8'd42;
	localparam logic [7:0] KEY_DIGIT_TWO  = 8'd50;
	localparam logic [7:0] KEY_DIGIT_ZERO = 8'd48;

	localparam logic [3:0] MAX_TRIES_RST = 4'd3;

	localparam logic [2:0] ST_KEY_TAKEN    = 3'd0;
	localparam logic [2:0] ST_CODE_OK      = 3'd1;
	localparam logic [2:0] ST_WRONG_RETRY  = 3'd2;
	localparam logic [2:0] ST_WRONG_ALARM  = 3'd3;
	localparam logic [2:0] ST_CHANGE_START = 3'd4;
	localparam logic [2:0] ST_CONFIRM_NEXT = 3'd5;
	localparam logic [2:0] ST_UPDATED      = 3'd6;
	localparam logic [2:0] ST_MISMATCH     = 3'd7;

	typedef struct packed {
		logic       vld;
		logic [7:0] key;
	} key_stage_t;

	typedef struct packed {
		logic [2:0] status;
		logic       locked;
		logic [3:0] tries;
	} lock_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/clc_key_stage.sv -----
// Input register of the code lock controller: holds one key until it is processed.
// Depends on clc_pkg.
`default_nettype none

module clc_key_stage
	import clc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] key,
	input  wire logic       advance,
	output key_stage_t      stage
);

	logic       valid_s1;
	logic [7:0] key_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1 <= key;
		end
	end

	assign stage.vld = valid_s1;
	assign stage.key = key_s1;

endmodule

`default_nettype wire

// ----- rtl/core/clc_lock_fsm.sv -----
// Lock state, code stores, try counter and the per-key decision logic.
// Depends on clc_pkg.
`default_nettype none

module clc_lock_fsm
	import clc_pkg::*;
#(
	parameter int CODE_LEN = CodeLenDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] key,
	input  wire logic [3:0] max_tries,
	output lock_result_t    result
);

	localparam int PosW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
	localparam logic [PosW-1:0] PosLast = PosW'(CODE_LEN - 1);

	localparam logic [1:0] PH_ENTRY   = 2'd0;
	localparam logic [1:0] PH_NEW     = 2'd1;
	localparam logic [1:0] PH_CONFIRM = 2'd2;

	logic [1:0]      phase_q, phase_d;
	logic [PosW-1:0] pos_q, pos_d, pos_inc;
	logic            lock_q, lock_d;
	logic [3:0]      tries_q, tries_d;
	logic [2:0]      status_d;
	logic            wr_entered, wr_pending, load_stored;
	logic            last;
	logic            match_stored, match_pending;

	logic [7:0] entered_q [CODE_LEN];
	logic [7:0] pending_q [CODE_LEN];
	logic [7:0] stored_q  [CODE_LEN];
	logic [7:0] cand      [CODE_LEN];

	assign last    = (pos_q == PosLast);
	assign pos_inc = pos_q + PosW'(1);

	always_comb begin
		match_stored  = 1'b1;
		match_pending = 1'b1;
		for (int j = 0; j < CODE_LEN; j++) begin
			cand[j] = (pos_q == PosW'(j)) ? key : entered_q[j];
			if (cand[j] != stored_q[j]) begin
				match_stored = 1'b0;
			end
			if (cand[j] != pending_q[j]) begin
				match_pending = 1'b0;
			end
		end
	end

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		lock_d      = lock_q;
		tries_d     = tries_q;
		status_d    = ST_KEY_TAKEN;
		wr_entered  = 1'b0;
		wr_pending  = 1'b0;
		load_stored = 1'b0;
		unique case (phase_q)
			PH_NEW: begin
				wr_pending = 1'b1;
				if (last) begin
					pos_d    = '0;
					phase_d  = PH_CONFIRM;
					status_d = ST_CONFIRM_NEXT;
				end else begin
					pos_d = pos_inc;
				end
			end
			PH_CONFIRM: begin
				wr_entered = 1'b1;
				if (last) begin
					pos_d = '0;
					if (match_pending) begin
						load_stored = 1'b1;
						tries_d     = max_tries;
						phase_d     = PH_ENTRY;
						status_d    = ST_UPDATED;
					end else begin
						phase_d  = PH_NEW;
						status_d = ST_MISMATCH;
					end
				end else begin
					pos_d = pos_inc;
				end
			end
			default: begin
				phase_d = PH_ENTRY;
				if (pos_q == '0 && key == STAR_KEY) begin
					phase_d  = PH_NEW;
					status_d = ST_CHANGE_START;
				end else begin
					wr_entered = 1'b1;
					if (last) begin
						pos_d = '0;
						if (match_stored) begin
							lock_d   = !lock_q;
							tries_d  = max_tries;
							status_d = ST_CODE_OK;
						end else if (tries_q <= 4'd1) begin
							tries_d  = max_tries;
							status_d = ST_WRONG_ALARM;
						end else begin
							tries_d  = tries_q - 4'd1;
							status_d = ST_WRONG_RETRY;
						end
					end else begin
						pos_d = pos_inc;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ENTRY;
			pos_q   <= '0;
			lock_q  <= 1'b0;
			tries_q <= MAX_TRIES_RST;
			for (int j = 0; j < CODE_LEN; j++) begin
				stored_q[j] <= (j == 0) ? KEY_DIGIT_TWO : KEY_DIGIT_ZERO;
			end
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			lock_q  <= lock_d;
			tries_q <= tries_d;
			if (load_stored) begin
				for (int j = 0; j < CODE_LEN; j++) begin
					stored_q[j] <= pending_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_entered) begin
			entered_q[pos_q] <= key;
		end
		if (step && wr_pending) begin
			pending_q[pos_q] <= key;
		end
	end

	assign result.status = status_d;
	assign result.locked = lock_d;
	assign result.tries  = tries_d;

`ifndef SYNTHESIS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosLast)
		else $error("Key position beyond the code length.");

	a_phase_valid: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("Unused phase code reached.");

	a_ok_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		step && status_d == ST_CODE_OK |=> lock_q != $past(lock_q))
		else $error("Correct code did not toggle the lock.");

	a_lock_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		step && status_d != ST_CODE_OK |=> lock_q == $past(lock_q))
		else $error("Lock changed without a correct code.");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/code_lock_controller.sv -----
// Top level of the code lock controller: configuration register, key stage,
// lock logic and result register. Depends on clc_pkg, clc_key_stage, clc_lock_fsm.
//
// Usage: each key character arrives as one transfer on the in_valid/in_ready
// channel and produces exactly one result transfer on out_valid/out_ready,
// carrying status, the lock drive and the remaining tries after that key.
// A key is first captured in the input register; its result is then written
// into the output register, which drives out_valid. A new key can be taken
// every cycle: the input register accepts while it is empty or while the
// output register is empty or being drained.
// If the receiver stalls, the result waits in the output register, one further
// key waits in the input register, and then in_ready falls until out_ready.
// The max_tries register is written by a transfer on cfg_valid/cfg_ready,
// which is always ready; a new value applies at the next reload of the count.
// Reset clears both registers' valid flags, unlocks, sets the stored code to
// "200", the try count and max_tries to three, and returns to code entry.
`default_nettype none

module code_lock_controller
	import clc_pkg::*;
#(
	parameter int CODE_LEN = CodeLenDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] key,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      status,
	output logic            locked,
	output logic [3:0]      tries_left,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] max_tries
);

	key_stage_t   stage;
	lock_result_t result;
	logic         advance;
	logic         out_valid_q;
	logic [3:0]   max_tries_q;
	logic [2:0]   status_q;
	logic         locked_q;
	logic [3:0]   tries_left_q;

	assign cfg_ready = 1'b1;
	assign advance   = stage.vld && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q <= MAX_TRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_tries_q <= max_tries;
		end
	end

	clc_key_stage u_key_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.key      (key),
		.advance  (advance),
		.stage    (stage)
	);

	clc_lock_fsm #(
		.CODE_LEN (CODE_LEN)
	) u_lock_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.key       (stage.key),
		.max_tries (max_tries_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q     <= result.status;
			locked_q     <= result.locked;
			tries_left_q <= result.tries;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign locked     = locked_q;
	assign tries_left = tries_left_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for code_lock_controller: key entry, code change and alarm paths.
// Depends on clc_pkg and the code_lock_controller RTL; a scoreboard class predicts each result.
`timescale 1ns / 100ps

module tb;
	import clc_pkg::*;

	localparam int CODE_LEN = CodeLenDef;
	localparam int CODE_W = CODE_LEN * 8;

	typedef logic [CODE_W-1:0] code_t;
	typedef enum logic [1:0] {CP_ENTRY, CP_NEW, CP_CONFIRM} code_phase_e;

	class lock_tracker;
		code_phase_e phase;
		int position;
		code_t attempt;
		code_t pending_code;
		code_t stored_code;
		logic [3:0] tries_count;
		logic [3:0] reload_value;
		logic lock_state;
		lock_result_t expected_results[$];
		int errors;
		int checked;
		int status_seen[8];

		function new();
			phase = CP_ENTRY;
			position = 0;
			attempt = '0;
			pending_code = '0;
			stored_code = {CODE_LEN{KEY_DIGIT_ZERO}};
			stored_code[7:0] = KEY_DIGIT_TWO;
			tries_count = MAX_TRIES_RST;
			reload_value = MAX_TRIES_RST;
			lock_state = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void take_key(input logic [7:0] k);
			lock_result_t r;
			int p;
			p = (position >= CODE_LEN) ? 0 : position;
			r.status = ST_KEY_TAKEN;
			case (phase)
				CP_NEW: begin
					pending_code[p*8 +: 8] = k;
					p++;
					if (p >= CODE_LEN) begin
						p = 0;
						phase = CP_CONFIRM;
						r.status = ST_CONFIRM_NEXT;
					end
				end
				CP_CONFIRM: begin
					attempt[p*8 +: 8] = k;
					p++;
					if (p >= CODE_LEN) begin
						p = 0;
						if (attempt == pending_code) begin
							stored_code = pending_code;
							tries_count = reload_value;
							phase = CP_ENTRY;
							r.status = ST_UPDATED;
						end else begin
							phase = CP_NEW;
							r.status = ST_MISMATCH;
						end
					end
				end
				default: begin
					phase = CP_ENTRY;
					if (p == 0 && k == STAR_KEY) begin
						phase = CP_NEW;
						r.status = ST_CHANGE_START;
					end else begin
						attempt[p*8 +: 8] = k;
						p++;
						if (p >= CODE_LEN) begin
							p = 0;
							if (attempt == stored_code) begin
								lock_state = ~lock_state;
								tries_count = reload_value;
								r.status = ST_CODE_OK;
							end else if (tries_count <= 4'd1) begin
								tries_count = reload_value;
								r.status = ST_WRONG_ALARM;
							end else begin
								tries_count = tries_count - 4'd1;
								r.status = ST_WRONG_RETRY;
							end
						end
					end
				end
			endcase
			position = p;
			r.locked = lock_state;
			r.tries = tries_count;
			expected_results.push_back(r);
		endfunction

		function void check_result(input logic [2:0] st, input logic lk, input logic [3:0] tr);
			lock_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with none expected: status=%0d locked=%0b tries=%0d",
						$time, st, lk, tr);
				return;
			end
			want = expected_results.pop_front();
			checked++;
			status_seen[want.status]++;
			if (st !== want.status || lk !== want.locked || tr !== want.tries) begin
				errors++;
				if (errors <= 10)
					$display("%0t: expected status=%0d locked=%0b tries=%0d, got status=%0d locked=%0b tries=%0d",
						$time, want.status, want.locked, want.tries, st, lk, tr);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] key = 8'h00;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [3:0] max_tries = MAX_TRIES_RST;
	logic in_ready;
	logic out_valid;
	logic [2:0] status;
	logic locked;
	logic [3:0] tries_left;
	logic cfg_ready;

	lock_tracker sb;
	int idle_pct = 0;
	int stall_pct = 0;
	int keys_sent = 0;

	logic [7:0] directed_keys [25] = '{
		KEY_DIGIT_TWO, KEY_DIGIT_ZERO, KEY_DIGIT_ZERO,
		8'h00, 8'hFF, STAR_KEY,
		8'h31, 8'h32, 8'h33,
		8'h39, 8'h39, 8'h39,
		STAR_KEY,
		STAR_KEY, 8'h00, 8'hFF,
		STAR_KEY, 8'h00, 8'hFE,
		8'h41, 8'h42, 8'h43,
		8'h41, 8'h42, 8'h43
	};

	code_lock_controller #(.CODE_LEN(CODE_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.locked(locked),
		.tries_left(tries_left),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_tries(max_tries)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, locked, tries_left);
	end

	task automatic send_key(input logic [7:0] k);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		do @(posedge clk); while (!in_ready);
		sb.take_key(k);
		keys_sent++;
	endtask

	task automatic send_code(input code_t c);
		for (int j = 0; j < CODE_LEN; j++)
			send_key(c[j*8 +: 8]);
	endtask

	task automatic write_max_tries(input logic [3:0] v);
		cfg_valid <= 1'b1;
		max_tries <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.reload_value = v;
	endtask

	task automatic wait_drained();
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic code_t random_code();
		code_t c;
		for (int j = 0; j < CODE_LEN; j++) begin
			case ($urandom_range(0, 7))
				0: c[j*8 +: 8] = STAR_KEY;
				1: c[j*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2, 3, 4: c[j*8 +: 8] = 8'($urandom_range(48, 57));
				default: c[j*8 +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return c;
	endfunction

	// Mostly whole attempts and code changes with random content, mixed with stray keys.
	task automatic run_random(input int target);
		code_t c;
		int r;
		int j;
		while (keys_sent < target) begin
			r = $urandom_range(0, 99);
			if (sb.phase == CP_NEW) begin
				send_code(random_code());
			end else if (sb.phase == CP_CONFIRM) begin
				c = sb.pending_code;
				if (r < 25) begin
					j = $urandom_range(0, CODE_LEN - 1);
					c[j*8 +: 8] ^= 8'($urandom_range(1, 255));
				end
				send_code(c);
			end else if (sb.position != 0) begin
				for (j = sb.position; j < CODE_LEN; j++)
					send_key($urandom_range(0, 1) ? sb.stored_code[j*8 +: 8]
						: 8'($urandom_range(0, 255)));
			end else if (r < 35) begin
				send_code(sb.stored_code);
			end else if (r < 60) begin
				c = sb.stored_code;
				j = $urandom_range(0, CODE_LEN - 1);
				c[j*8 +: 8] ^= 8'($urandom_range(1, 255));
				send_code(c);
			end else if (r < 68) begin
				repeat (sb.tries_count) begin
					c = random_code();
					if (c[7:0] == STAR_KEY)
						c[7:0] = 8'h23;
					send_code(c);
				end
			end else if (r < 80) begin
				send_key(STAR_KEY);
			end else begin
				send_key(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [3:0] cfg_list [6];
		int target;
		sb = new();
		idle_pct = 20;
		stall_pct = 8;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_keys[i])
			send_key(directed_keys[i]);
		in_valid <= 1'b0;
		target = keys_sent;
		cfg_list = '{4'd1, 4'd15, 4'd8, 4'($urandom_range(2, 14)), 4'd2,
			4'($urandom_range(1, 15))};
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_max_tries(cfg_list[ph]);
			if (ph == 5) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
			end
			target += 290;
			run_random(target);
			in_valid <= 1'b0;
		end
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d keys over seven try limits; %0d results checked, %0d in error.",
			keys_sent, sb.checked, sb.errors);
		$display("Seen: %0d toggles, %0d retries, %0d alarms, %0d changes, %0d updates, %0d mismatches.",
			sb.status_seen[ST_CODE_OK], sb.status_seen[ST_WRONG_RETRY],
			sb.status_seen[ST_WRONG_ALARM], sb.status_seen[ST_CHANGE_START],
			sb.status_seen[ST_UPDATED], sb.status_seen[ST_MISMATCH]);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/clc_pkg.sv
rtl/core/clc_key_stage.sv
rtl/core/clc_lock_fsm.sv
rtl/core/code_lock_controller.sv
tb/tb.sv
